// File: sv/dsrv_pkg.sv
// ----------------------------------------------------------------------------
// dsrv_pkg
// Shared types, constants and the byte-wide CRC-32 update for the dual slot
// record validator.
// ----------------------------------------------------------------------------
package dsrv_pkg;

    // record geometry
    localparam int RECORD_BYTES = 48;
    localparam int CRC_BYTES    = 44;
    localparam int IDX_W        = $clog2(RECORD_BYTES + 1);
    localparam int NUM_WORDS    = 5;
    localparam int WORD_IDX_W   = $clog2(NUM_WORDS);

    // byte positions
    localparam logic [IDX_W-1:0] POS_MAGIC0   = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_MAGIC1   = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_MAGIC2   = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_MAGIC3   = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_VERSION  = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_SIZE     = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_RSV0     = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_RSV1     = IDX_W'(7);
    localparam logic [IDX_W-1:0] POS_WORDS    = IDX_W'(8);
    localparam logic [IDX_W-1:0] POS_COINS_LO = IDX_W'(24);
    localparam logic [IDX_W-1:0] POS_COINS_HI = IDX_W'(25);
    localparam logic [IDX_W-1:0] POS_XP       = IDX_W'(26);
    localparam logic [IDX_W-1:0] POS_FULL     = IDX_W'(27);
    localparam logic [IDX_W-1:0] POS_ENERGY   = IDX_W'(28);
    localparam logic [IDX_W-1:0] POS_REST     = IDX_W'(29);
    localparam logic [IDX_W-1:0] POS_RSV_LO   = IDX_W'(30);
    localparam logic [IDX_W-1:0] POS_CRC      = IDX_W'(CRC_BYTES);
    localparam logic [IDX_W-1:0] POS_END      = IDX_W'(RECORD_BYTES);

    localparam logic [WORD_IDX_W-1:0] WORD_BASE = WORD_IDX_W'(POS_WORDS >> 2);
    localparam logic [WORD_IDX_W-1:0] WORD_CRC  = WORD_IDX_W'(NUM_WORDS - 1);

    // header contents
    localparam logic [7:0] MAGIC0      = 8'h50;
    localparam logic [7:0] MAGIC1      = 8'h45;
    localparam logic [7:0] MAGIC2      = 8'h54;
    localparam logic [7:0] MAGIC3      = 8'h31;
    localparam logic [7:0] VERSION     = 8'd1;
    localparam logic [7:0] SIZE_BYTE   = 8'(RECORD_BYTES);

    // field limits
    localparam logic [15:0] COINS_MAX  = 16'd999;
    localparam logic [7:0]  PCT_MAX    = 8'd100;
    localparam logic [7:0]  REST_MAX   = 8'd1;
    localparam logic [31:0] SERIAL_HALF = 32'h8000_0000;

    // crc
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

    // configuration registers
    localparam int          CFG_IDX_W   = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = CFG_IDX_W'(1);
    localparam logic [7:0]  MAX_EXP_RST = 8'd56;
    localparam logic [31:0] PERIOD_RST  = 32'd60000;

    typedef enum logic [1:0] {
        OUT_USE_A = 2'd0,
        OUT_USE_B = 2'd1,
        OUT_NONE  = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] seq;
        logic [31:0] cycles;
        logic [31:0] phase;
        logic [15:0] coins;
        logic [7:0]  xp;
        logic [6:0]  full;
        logic [6:0]  energy;
        logic        rest;
    } t_rec_fields;

    // one finished record, handed from the accumulator to the selector
    typedef struct packed {
        logic        slot_b;
        logic        empty;
        logic        fmt_ok;
        logic        len_ok;
        logic [31:0] crc_calc;
        logic [31:0] crc_stored;
        t_rec_fields fields;
    } t_rec_event;

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] v);
        logic [31:0] c;
        c = crc ^ {24'd0, v};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// File: sv/dsrv_accum.sv
// ----------------------------------------------------------------------------
// dsrv_accum
// Per-byte record accumulator: crc, format checks and field capture. Each
// record end is registered as one event for the selector.
// ----------------------------------------------------------------------------
module dsrv_accum
    import dsrv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_slot,
    input  logic       i_last,
    input  logic       i_empty,
    output logic       o_ready,
    output logic       o_evt_valid,
    output t_rec_event o_evt,
    input  logic       i_evt_ready
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]      r_crc, n_crc;
    logic             r_fmt, n_fmt;
    logic [31:0]      r_words [NUM_WORDS];
    logic [31:0]      n_words [NUM_WORDS];
    logic [15:0]      r_coins, n_coins;
    logic [7:0]       r_xp, n_xp;
    logic [6:0]       r_full, n_full;
    logic [6:0]       r_energy, n_energy;
    logic             r_rest, n_rest;
    logic             r_evt_valid, n_evt_valid;
    t_rec_event       r_evt, n_evt;

    logic             accept;
    logic             rec_end;
    logic             in_rsv;
    logic [4:0]       lane_sh;
    logic [WORD_IDX_W-1:0] widx;

    assign o_ready     = !r_evt_valid || i_evt_ready;
    assign accept      = i_valid && o_ready;
    assign rec_end     = i_empty || i_last;
    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

    assign in_rsv  = (r_idx == POS_RSV0) || (r_idx == POS_RSV1) ||
                     ((r_idx >= POS_RSV_LO) && (r_idx < POS_CRC));
    assign lane_sh = {r_idx[1:0], 3'b000};
    assign widx    = (r_idx >= POS_CRC) ? WORD_CRC : (WORD_IDX_W'(r_idx[4:2]) - WORD_BASE);

    always_comb begin
        // byte applied to the running record
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_fmt    = r_fmt;
        n_words  = r_words;
        n_coins  = r_coins;
        n_xp     = r_xp;
        n_full   = r_full;
        n_energy = r_energy;
        n_rest   = r_rest;
        if (!i_empty) begin
            if (r_idx >= POS_END) begin
                n_fmt = 1'b0;
            end else begin
                if (r_idx < POS_CRC) begin
                    n_crc = crc32_byte(r_crc, i_byte);
                end
                case (r_idx)
                    POS_MAGIC0:   if (i_byte != MAGIC0) n_fmt = 1'b0;
                    POS_MAGIC1:   if (i_byte != MAGIC1) n_fmt = 1'b0;
                    POS_MAGIC2:   if (i_byte != MAGIC2) n_fmt = 1'b0;
                    POS_MAGIC3:   if (i_byte != MAGIC3) n_fmt = 1'b0;
                    POS_VERSION:  if (i_byte != VERSION) n_fmt = 1'b0;
                    POS_SIZE:     if (i_byte != SIZE_BYTE) n_fmt = 1'b0;
                    POS_COINS_LO: n_coins[7:0]  = i_byte;
                    POS_COINS_HI: n_coins[15:8] = i_byte;
                    POS_XP:       n_xp = i_byte;
                    POS_FULL: begin
                        if (i_byte > PCT_MAX) n_fmt = 1'b0;
                        n_full = i_byte[6:0];
                    end
                    POS_ENERGY: begin
                        if (i_byte > PCT_MAX) n_fmt = 1'b0;
                        n_energy = i_byte[6:0];
                    end
                    POS_REST: begin
                        if (i_byte > REST_MAX) n_fmt = 1'b0;
                        n_rest = i_byte[0];
                    end
                    default: ;
                endcase
                if (in_rsv && (i_byte != 8'd0)) n_fmt = 1'b0;
                // words are zero at record start, so a lane write is an or
                if (((r_idx >= POS_WORDS) && (r_idx < POS_COINS_LO)) || (r_idx >= POS_CRC)) begin
                    n_words[widx][lane_sh +: 8] = i_byte;
                end
                n_idx = r_idx + IDX_W'(1);
            end
        end

        n_evt_valid = r_evt_valid && !i_evt_ready;
        n_evt       = r_evt;
        if (accept && rec_end) begin
            n_evt_valid           = 1'b1;
            n_evt.slot_b          = i_slot;
            n_evt.empty           = i_empty;
            n_evt.fmt_ok          = n_fmt;
            n_evt.len_ok          = (n_idx == POS_END);
            n_evt.crc_calc        = ~n_crc;
            n_evt.crc_stored      = n_words[WORD_CRC];
            n_evt.fields.id       = n_words[0];
            n_evt.fields.seq      = n_words[1];
            n_evt.fields.cycles   = n_words[2];
            n_evt.fields.phase    = n_words[3];
            n_evt.fields.coins    = n_coins;
            n_evt.fields.xp       = n_xp;
            n_evt.fields.full     = n_full;
            n_evt.fields.energy   = n_energy;
            n_evt.fields.rest     = n_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_crc       <= CRC_INIT;
            r_fmt       <= 1'b1;
            r_coins     <= '0;
            r_xp        <= '0;
            r_full      <= '0;
            r_energy    <= '0;
            r_rest      <= 1'b0;
            r_evt_valid <= 1'b0;
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_words[w] <= '0;
            end
        end else begin
            r_evt_valid <= n_evt_valid;
            if (accept) begin
                if (rec_end) begin
                    // start the next record
                    r_idx    <= '0;
                    r_crc    <= CRC_INIT;
                    r_fmt    <= 1'b1;
                    r_coins  <= '0;
                    r_xp     <= '0;
                    r_full   <= '0;
                    r_energy <= '0;
                    r_rest   <= 1'b0;
                    for (int w = 0; w < NUM_WORDS; w++) begin
                        r_words[w] <= '0;
                    end
                end else begin
                    r_idx    <= n_idx;
                    r_crc    <= n_crc;
                    r_fmt    <= n_fmt;
                    r_coins  <= n_coins;
                    r_xp     <= n_xp;
                    r_full   <= n_full;
                    r_energy <= n_energy;
                    r_rest   <= n_rest;
                    r_words  <= n_words;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_evt <= n_evt;
    end

endmodule

// File: sv/dsrv_select.sv
// ----------------------------------------------------------------------------
// dsrv_select
// Record validation, slot A hold and the A/B choice, with the result
// register that feeds the output stream.
// ----------------------------------------------------------------------------
module dsrv_select
    import dsrv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_max_exp,
    input  logic [31:0] i_period,
    input  logic        i_evt_valid,
    input  t_rec_event  i_evt,
    output logic        o_evt_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output t_outcome    o_outcome,
    output t_rec_fields o_fields
);

    logic        r_held_valid, n_held_valid;
    t_rec_fields r_held;
    logic        held_we;
    logic        r_out_valid, n_out_valid;
    t_outcome    r_outcome, n_outcome;
    t_rec_fields r_out, n_out;

    logic        out_free;
    logic        consume;
    logic        rec_ok;
    logic [31:0] seq_diff;
    logic        use_b;

    assign out_free    = !r_out_valid || i_ready;
    assign o_evt_ready = !i_evt.slot_b || out_free;
    assign consume     = i_evt_valid && o_evt_ready;

    assign rec_ok = !i_evt.empty && i_evt.fmt_ok && i_evt.len_ok &&
                    (i_evt.crc_calc == i_evt.crc_stored) &&
                    (i_evt.fields.id != 32'd0) &&
                    (i_evt.fields.coins <= COINS_MAX) &&
                    (i_evt.fields.xp <= i_max_exp) &&
                    (i_evt.fields.phase < i_period);

    // serial-number compare: b newer when the forward distance is under half
    assign seq_diff = i_evt.fields.seq - r_held.seq;
    assign use_b    = rec_ok && (!r_held_valid ||
                      ((i_evt.fields.seq != r_held.seq) && (seq_diff < SERIAL_HALF)));

    assign o_valid   = r_out_valid;
    assign o_outcome = r_outcome;
    assign o_fields  = r_out;

    always_comb begin
        n_held_valid = r_held_valid;
        held_we      = 1'b0;
        n_out_valid  = r_out_valid && !i_ready;
        n_outcome    = r_outcome;
        n_out        = r_out;
        if (consume) begin
            if (!i_evt.slot_b) begin
                n_held_valid = rec_ok;
                held_we      = rec_ok;
            end else begin
                n_out_valid  = 1'b1;
                n_held_valid = 1'b0;
                if (!rec_ok && !r_held_valid) begin
                    n_outcome = OUT_NONE;
                    n_out     = '0;
                end else if (use_b) begin
                    n_outcome = OUT_USE_B;
                    n_out     = i_evt.fields;
                end else begin
                    n_outcome = OUT_USE_A;
                    n_out     = r_held;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held <= i_evt.fields;
        end
        r_outcome <= n_outcome;
        r_out     <= n_out;
    end

endmodule

// File: sv/dual_slot_record_validator_unit.sv
// ----------------------------------------------------------------------------
// dual_slot_record_validator_unit
// Validates two stored save records and picks the one to use.
// ----------------------------------------------------------------------------
// Record bytes stream in one byte per cycle while the input is ready, slot A's
// record first, then slot B's. Each byte goes straight into the accumulator
// (crc-32 byte update and format checks), so the input takes a byte every cycle
// unless stalled. A record end is registered as an event; the selector then
// validates it, holds slot A, and on slot B's end loads the result register
// from the registered event. The input stalls only while a slot B result is
// waiting behind an output word that has not been taken. Configuration
// writes are always accepted and must be made while no record is in flight.
module dual_slot_record_validator_unit
    import dsrv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] data_byte
    input  logic                 i_s_tlast,   // last_byte
    input  logic [1:0]           i_s_tuser,   // [0] slot, [1] slot_empty
    // master stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [167:0]         o_m_tdata,   // [31:0] id, [63:32] sequence_res,
                                              // [95:64] cycles, [127:96] cycle_phase,
                                              // [137:128] coins, [145:138] experience,
                                              // [152:146] fullness, [159:153] energy,
                                              // [160] resting, [167:161] zero
    output logic [1:0]           o_m_tuser,   // [1:0] outcome
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [7:0]  r_max_exp;
    logic [31:0] r_period;

    logic        evt_valid;
    logic        evt_ready;
    t_rec_event  evt;
    t_outcome    sel_outcome;
    t_rec_fields sel_fields;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_exp <= MAX_EXP_RST;
            r_period  <= PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_EXP: r_max_exp <= i_cfg_data[7:0];
                CFG_PERIOD:  r_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dsrv_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .i_slot      (i_s_tuser[0]),
        .i_last      (i_s_tlast),
        .i_empty     (i_s_tuser[1]),
        .o_ready     (o_s_tready),
        .o_evt_valid (evt_valid),
        .o_evt       (evt),
        .i_evt_ready (evt_ready)
    );

    dsrv_select u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_exp   (r_max_exp),
        .i_period    (r_period),
        .i_evt_valid (evt_valid),
        .i_evt       (evt),
        .o_evt_ready (evt_ready),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_outcome   (sel_outcome),
        .o_fields    (sel_fields)
    );

    assign o_m_tuser = sel_outcome;
    assign o_m_tdata = {7'd0, sel_fields.rest, sel_fields.energy, sel_fields.full,
                        sel_fields.xp, sel_fields.coins[9:0], sel_fields.phase,
                        sel_fields.cycles, sel_fields.seq, sel_fields.id};

endmodule

// File: sv/dsrv_checker.sv
// ----------------------------------------------------------------------------
// dsrv_checker
// Port-level checks of the record validator, bound to the top level.
// ----------------------------------------------------------------------------
module dsrv_checker
    import dsrv_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [167:0] o_m_tdata,
    input logic [1:0]   o_m_tuser
);

    // a waiting result word holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // with the result register empty nothing can block the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == OUT_USE_A) || (o_m_tuser == OUT_USE_B) ||
                       (o_m_tuser == OUT_NONE))
        else $error("undefined outcome code");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == OUT_NONE) |-> (o_m_tdata == '0))
        else $error("no-record result carries data");

    // a chosen record passed validation
    a_chosen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != OUT_NONE) |->
            (o_m_tdata[31:0] != 32'd0) && (o_m_tdata[137:128] <= COINS_MAX[9:0]) &&
            (o_m_tdata[152:146] <= PCT_MAX[6:0]) && (o_m_tdata[159:153] <= PCT_MAX[6:0]))
        else $error("chosen record out of range");

endmodule

bind dual_slot_record_validator_unit dsrv_checker u_dsrv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
